[rtl/core/ncp_pkg.sv]
// Shared constants, codes and types of the nearest color palette table.
`default_nettype none

package ncp_pkg;

  localparam int unsigned ENTRIES_DEF      = 64;
  localparam int unsigned CHANNEL_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned KEY_CH_W  = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned IDX_FLD_W = 6;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned OCC_W     = 7;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  CFG_REG_TOLERANCE = 1'b0;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADIDX  = 3'd5;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_ADD,
    OP_REMOVE
  } ncp_op_t;

  typedef struct packed {
    ncp_op_t                op;
    logic [KEY_CH_W-1:0]    red;
    logic [KEY_CH_W-1:0]    green;
    logic [KEY_CH_W-1:0]    blue;
    logic [IDX_FLD_W-1:0]   entry_index;
  } ncp_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [DIST_W-1:0]   distance;
    logic [OCC_W-1:0]    occupancy;
  } ncp_res_t;

endpackage

`default_nettype wire

[rtl/core/ncp_front.sv]
// Request front end: registers an incoming request, decodes its mode and masks the key.
`default_nettype none

module ncp_front #(
  parameter int unsigned CHANNEL_BITS = ncp_pkg::CHANNEL_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [ncp_pkg::MODE_W-1:0]         in_mode,
  input  wire [ncp_pkg::KEY_CH_W-1:0]       in_red,
  input  wire [ncp_pkg::KEY_CH_W-1:0]       in_green,
  input  wire [ncp_pkg::KEY_CH_W-1:0]       in_blue,
  input  wire [ncp_pkg::IDX_FLD_W-1:0]      in_entry_index,
  output logic                              push_valid,
  input  wire                               push_ready,
  output ncp_pkg::ncp_cmd_t                 push_cmd
);

  localparam logic [ncp_pkg::KEY_CH_W-1:0] CH_MASK =
    ncp_pkg::KEY_CH_W'((33'd1 << CHANNEL_BITS) - 33'd1);

  logic              valid_r;
  logic              valid_nxt;
  ncp_pkg::ncp_cmd_t cmd_r;
  ncp_pkg::ncp_cmd_t cmd_nxt;
  logic              take;

  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    cmd_nxt = cmd_r;
    if (take) begin
      unique case (in_mode)
        ncp_pkg::MODE_ADD:    cmd_nxt.op = ncp_pkg::OP_ADD;
        ncp_pkg::MODE_REMOVE: cmd_nxt.op = ncp_pkg::OP_REMOVE;
        default:              cmd_nxt.op = ncp_pkg::OP_LOOKUP;
      endcase
      cmd_nxt.red         = in_red & CH_MASK;
      cmd_nxt.green       = in_green & CH_MASK;
      cmd_nxt.blue        = in_blue & CH_MASK;
      cmd_nxt.entry_index = in_entry_index;
    end
  end

  assign valid_nxt = take || (valid_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/ncp_queue.sv]
// Short request queue between the front end and the table engine.
`default_nettype none

module ncp_queue #(
  parameter int unsigned DEPTH = ncp_pkg::QUEUE_DEPTH
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr_valid,
  output logic              wr_ready,
  input  ncp_pkg::ncp_cmd_t wr_cmd,
  output logic              rd_valid,
  input  wire               rd_ready,
  output ncp_pkg::ncp_cmd_t rd_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ncp_pkg::ncp_cmd_t slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (fill_r != CNT_W'(DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_cmd   = slots_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ncp_engine.sv]
// Table engine: palette memory, entry count, nearest-color scan and result register.
`default_nettype none

module ncp_engine #(
  parameter int unsigned ENTRIES      = ncp_pkg::ENTRIES_DEF,
  parameter int unsigned CHANNEL_BITS = ncp_pkg::CHANNEL_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire [ncp_pkg::DIST_W-1:0]      tolerance,
  input  wire                            cmd_valid,
  output logic                           cmd_ready,
  input  ncp_pkg::ncp_cmd_t              cmd,
  output logic                           res_valid,
  input  wire                            res_ready,
  output ncp_pkg::ncp_res_t              res
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned WORD_W = 3 * CB;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_RMWR   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [WORD_W-1:0] mem [ENTRIES];

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  ncp_pkg::ncp_cmd_t             cmd_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic [CNT_W-1:0]              scan_addr_r;
  logic                          v1_r;
  logic                          v2_r;
  logic [IDX_W-1:0]              tag1_r;
  logic [IDX_W-1:0]              tag2_r;
  logic [WORD_W-1:0]             rdata_r;
  logic [ncp_pkg::DIST_W-1:0]    dist_r;
  logic [ncp_pkg::DIST_W-1:0]    dist_nxt;
  logic [ncp_pkg::DIST_W-1:0]    best_dis_r;
  logic [IDX_W-1:0]              best_idx_r;
  logic [ncp_pkg::STATUS_W-1:0]  rstat_r;
  logic [ncp_pkg::STATUS_W-1:0]  rstat_nxt;
  logic [ncp_pkg::SLOT_W-1:0]    rslot_r;
  logic [ncp_pkg::SLOT_W-1:0]    rslot_nxt;
  logic [ncp_pkg::DIST_W-1:0]    rdist_r;
  logic [ncp_pkg::DIST_W-1:0]    rdist_nxt;
  logic                          out_valid_r;
  ncp_pkg::ncp_res_t             out_r;

  logic [CNT_W-1:0]              last_idx;
  logic [31:0]                   idx_ext;
  logic                          idx_ok;
  logic                          scan_issue;
  logic                          table_empty;
  logic                          table_full;
  logic                          is_hit;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [WORD_W-1:0]             mem_wdata;
  logic [IDX_W-1:0]              mem_raddr;
  logic [WORD_W-1:0]             key_word;
  logic [CB-1:0]                 pr;
  logic [CB-1:0]                 pg;
  logic [CB-1:0]                 pb;
  logic [CB-1:0]                 ar;
  logic [CB-1:0]                 ag;
  logic [CB-1:0]                 ab;
  logic                          load_out;

  assign cmd_ready   = (state_r == S_IDLE);
  assign res_valid   = out_valid_r;
  assign res         = out_r;

  assign last_idx    = count_r - CNT_W'(1);
  assign idx_ext     = 32'(cmd_r.entry_index);
  assign idx_ok      = idx_ext < 32'(count_r);
  assign scan_issue  = (state_r == S_SCAN) && (scan_addr_r < count_r);
  assign table_empty = (count_r == '0);
  assign table_full  = (count_r >= CNT_W'(ENTRIES));
  assign is_hit      = !table_empty && (best_dis_r <= tolerance);
  assign key_word    = {cmd_r.red[CB-1:0], cmd_r.green[CB-1:0], cmd_r.blue[CB-1:0]};
  assign load_out    = (state_r == S_RESULT) && (!out_valid_r || res_ready);

  // Distance of the word read last cycle to the key.
  assign pr = rdata_r[3*CB-1:2*CB];
  assign pg = rdata_r[2*CB-1:CB];
  assign pb = rdata_r[CB-1:0];
  assign ar = (pr >= cmd_r.red[CB-1:0])   ? pr - cmd_r.red[CB-1:0]   : cmd_r.red[CB-1:0] - pr;
  assign ag = (pg >= cmd_r.green[CB-1:0]) ? pg - cmd_r.green[CB-1:0] : cmd_r.green[CB-1:0] - pg;
  assign ab = (pb >= cmd_r.blue[CB-1:0])  ? pb - cmd_r.blue[CB-1:0]  : cmd_r.blue[CB-1:0] - pb;
  assign dist_nxt = ncp_pkg::DIST_W'(ar) + ncp_pkg::DIST_W'(ag) + ncp_pkg::DIST_W'(ab);

  always_comb begin
    mem_raddr = scan_addr_r[IDX_W-1:0];
    if (state_r == S_START) begin
      mem_raddr = last_idx[IDX_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rstat_nxt = rstat_r;
    rslot_nxt = rslot_r;
    rdist_nxt = rdist_r;
    mem_we    = 1'b0;
    mem_waddr = count_r[IDX_W-1:0];
    mem_wdata = key_word;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (cmd_r.op == ncp_pkg::OP_REMOVE) begin
          if (idx_ok) begin
            state_nxt = S_RMWR;
          end else begin
            rstat_nxt = ncp_pkg::ST_BADIDX;
            rslot_nxt = '0;
            rdist_nxt = '0;
            state_nxt = S_RESULT;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_issue && !v1_r && !v2_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_RMWR: begin
        // The last valid entry moves into the freed slot.
        mem_we    = 1'b1;
        mem_waddr = idx_ext[IDX_W-1:0];
        mem_wdata = rdata_r;
        count_nxt = last_idx;
        rstat_nxt = ncp_pkg::ST_REMOVED;
        rslot_nxt = '0;
        rdist_nxt = '0;
        state_nxt = S_RESULT;
      end
      S_DECIDE: begin
        rdist_nxt = table_empty ? '0 : best_dis_r;
        rslot_nxt = '0;
        priority if (is_hit) begin
          rstat_nxt = ncp_pkg::ST_HIT;
          rslot_nxt = ncp_pkg::SLOT_W'(32'(best_idx_r));
        end else if (cmd_r.op != ncp_pkg::OP_ADD) begin
          rstat_nxt = ncp_pkg::ST_MISS;
        end else if (table_full) begin
          rstat_nxt = ncp_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          rstat_nxt = ncp_pkg::ST_ADDED;
          rslot_nxt = ncp_pkg::SLOT_W'(32'(count_r));
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      v1_r    <= scan_issue;
      v2_r    <= v1_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
    if (state_r == S_START) begin
      scan_addr_r <= '0;
      best_dis_r  <= '1;
      best_idx_r  <= '0;
    end else begin
      if (scan_issue) begin
        scan_addr_r <= scan_addr_r + CNT_W'(1);
      end
      // Strict compare keeps the lowest index on ties.
      if (v2_r && (dist_r < best_dis_r)) begin
        best_dis_r <= dist_r;
        best_idx_r <= tag2_r;
      end
    end
    tag1_r  <= scan_addr_r[IDX_W-1:0];
    tag2_r  <= tag1_r;
    dist_r  <= dist_nxt;
    rstat_r <= rstat_nxt;
    rslot_r <= rslot_nxt;
    rdist_r <= rdist_nxt;
    if (load_out) begin
      out_r.status    <= rstat_r;
      out_r.slot      <= rslot_r;
      out_r.distance  <= rdist_r;
      out_r.occupancy <= ncp_pkg::OCC_W'(32'(count_r));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMWR) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("remove did not shrink the table by one");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && !table_empty) |-> (32'(best_idx_r) < 32'(count_r)))
    else $error("nearest entry outside the valid range");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r) |-> (state_r == S_SCAN))
    else $error("scan pipeline busy outside a scan");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result loaded outside the result state");
`endif

endmodule

`default_nettype wire

[rtl/core/nearest_color_palette_table_top.sv]
// Top level of the nearest color palette table: stream ports, register port and wiring.
`default_nettype none

// Channel    Dir  Handshake              Payload
// in_*       in   in_tvalid/in_tready    tuser: mode; tdata: red, green, blue, entry_index
// out_*      out  out_tvalid/out_tready  tuser: status; tdata: slot, distance, occupancy
// cfg_*      in   psel/penable, pready=1 register 0 (byte address 0): tolerance
//
// A lookup or add scans the palette one entry per cycle, then decides hit, miss, added or full;
// a remove moves the last valid entry into the freed slot, and a remove at an invalid index
// reports a bad index without touching the table. The engine takes the next queued request
// only when idle, that is after its last result has been loaded into the output register.
// Reset (rst_n low, synchronous) empties the table and clears the tolerance; the palette
// memory is not cleared. A two-entry queue feeds the engine, and an untaken result stalls it.

module nearest_color_palette_table_top #(
  parameter int unsigned ENTRIES      = ncp_pkg::ENTRIES_DEF,
  parameter int unsigned CHANNEL_BITS = ncp_pkg::CHANNEL_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // Input requests.
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [55:0]                        in_tdata,   // red, green, blue, entry_index
  input  wire [1:0]                         in_tuser,   // mode
  // Results.
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [31:0]                       out_tdata,  // slot, distance, occupancy
  output logic [2:0]                        out_tuser,  // status
  // Register port.
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire [ncp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire [ncp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ncp_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic [ncp_pkg::DIST_W-1:0] tol_r;
  logic [ncp_pkg::DIST_W-1:0] tol_nxt;
  logic                       cfg_wr;
  logic                       cfg_hit;

  logic                       fq_valid;
  logic                       fq_ready;
  ncp_pkg::ncp_cmd_t          fq_cmd;
  logic                       qe_valid;
  logic                       qe_ready;
  ncp_pkg::ncp_cmd_t          qe_cmd;
  ncp_pkg::ncp_res_t          res;

  // Register port: one register, selected by byte address bit 2, written in the
  // access cycle of a transfer.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == ncp_pkg::CFG_REG_TOLERANCE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign tol_nxt    = cfg_wr ? cfg_pwdata[ncp_pkg::DIST_W-1:0] : tol_r;
  assign cfg_prdata = cfg_hit ? ncp_pkg::CFG_DATA_W'(tol_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  ncp_front #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_mode        (in_tuser),
    .in_red         (in_tdata[15:0]),
    .in_green       (in_tdata[31:16]),
    .in_blue        (in_tdata[47:32]),
    .in_entry_index (in_tdata[53:48]),
    .push_valid     (fq_valid),
    .push_ready     (fq_ready),
    .push_cmd       (fq_cmd)
  );

  ncp_queue #(
    .DEPTH (ncp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qe_valid),
    .rd_ready (qe_ready),
    .rd_cmd   (qe_cmd)
  );

  ncp_engine #(
    .ENTRIES      (ENTRIES),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .tolerance (tol_r),
    .cmd_valid (qe_valid),
    .cmd_ready (qe_ready),
    .cmd       (qe_cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // The result word is packed from the lowest bit up; the top bit is padding.
  assign out_tdata = {1'b0, res.occupancy, res.distance, res.slot};
  assign out_tuser = res.status;

endmodule

`default_nettype wire
